// ===== design/dtc_pkg.sv =====
// shared constants, types and helper functions of the dictionary token counter
`default_nettype none

package dtc_pkg;

  localparam int NUM_FEATURES   = 32;
  localparam int MAX_NAME_BYTES = 16;

  localparam int REQ_W  = 2;
  localparam int SLOT_W = 5;
  localparam int NPOS_W = 4;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = 16;

  // slots an end of text reports
  localparam int REPORTED = (NUM_FEATURES < 32) ? NUM_FEATURES : 32;
  localparam int REP_W    = (REPORTED > 1) ? $clog2(REPORTED) : 1;

  // name table rows: one row per byte position, one byte lane per feature
  localparam int FEAT_W   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int ROW_W    = $clog2(MAX_NAME_BYTES);
  localparam int ROW_BITS = NUM_FEATURES * CHAR_W;

  // token position counts up to one past the name storage
  localparam int POS_W = $clog2(MAX_NAME_BYTES + 2);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_TEXT = 2'd1,
    REQ_END  = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_QUEST   = 8'h3f;
  localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5f;
  localparam logic [CHAR_W:0]   CASE_STEP  = 9'd32;
  localparam logic [CHAR_W:0]   ASCII_TOP  = 9'd128;

  function automatic logic is_token_byte(input logic [CHAR_W-1:0] b);
    return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
           ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ||
           (b == CH_QUEST) || (b == CH_UNDER);
  endfunction

  // name byte equals token byte, or token byte plus 32 while below 128
  function automatic logic byte_matches(input logic [CHAR_W-1:0] nb,
                                        input logic [CHAR_W-1:0] tok);
    logic [CHAR_W:0] up;
    up = {1'b0, tok} + CASE_STEP;
    return (nb == tok) || ((up < ASCII_TOP) && ({1'b0, nb} == up));
  endfunction

endpackage

`default_nettype wire

// ===== design/dtc_if.sv =====
// valid/ready channel interfaces for input items and count results
`default_nettype none

interface dtc_in_if import dtc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [SLOT_W-1:0] feature_slot;
  logic [NPOS_W-1:0] name_position;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, req_type, feature_slot, name_position, char_code,
                  input ready);
  modport sink   (input valid, req_type, feature_slot, name_position, char_code,
                  output ready);
endinterface

interface dtc_out_if import dtc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] result_slot;
  logic [CNT_W-1:0]  occurrences;
  logic              last_of_run;

  modport source (output valid, result_slot, occurrences, last_of_run,
                  input ready);
  modport sink   (input valid, result_slot, occurrences, last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ===== design/dictionary_token_counter.sv =====
// top level: whole-token dictionary counter over a byte stream
// a token byte within the name storage or a close of a countable token
//   passes a row read of the name memory, then a compare or count update;
//   every other load, text or unknown item is taken in the idle state alone
// an end of text closes a countable open token first, then hands over each count in turn
// throughput: one item in flight at a time, input ready only while idle
// reset: synchronous; counts, token state and output clear at once, then a
//   clearing pass zeroes every row of the name memory, ready low
`default_nettype none

module dictionary_token_counter import dtc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  dtc_in_if.sink    item,
  dtc_out_if.source result
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_STEP   = 5'b00100,
    ST_CLOSE  = 5'b01000,
    ST_REPORT = 5'b10000
  } state_t;

  state_t state;

  // token tracking
  logic [POS_W-1:0]        tok_pos;
  logic                    in_token;
  logic [NUM_FEATURES-1:0] still_matching;
  logic [CHAR_W-1:0]       ch_q;
  logic                    end_pending;

  // per-feature counts and report sequencing
  logic [CNT_W-1:0] hit_counts [NUM_FEATURES];
  logic [REP_W-1:0] rpt_idx;
  logic             rpt_last;

  // name memory: row = byte position, lane = feature
  logic [ROW_BITS-1:0] name_mem [MAX_NAME_BYTES];
  logic [ROW_BITS-1:0] rd_row;
  logic [ROW_W-1:0]    clr_row;

  logic              accept;
  logic              is_load;
  logic              is_text;
  logic              is_end;
  logic              tok_byte;
  logic              closes;
  logic [POS_W-1:0]  eff_pos;
  logic              adv_fits;
  logic              close_live;
  logic              rd_en;
  logic [ROW_W-1:0]  rd_addr;
  logic              wr_load;
  logic [FEAT_W-1:0] wr_lane;
  logic [ROW_W-1:0]  wr_row;
  logic              out_xfer;
  logic              counts_nonzero;

  // request decode
  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign is_load    = (item.req_type == REQ_LOAD);
  assign is_text    = (item.req_type == REQ_TEXT);
  assign is_end     = (item.req_type == REQ_END);
  assign tok_byte   = is_token_byte(item.char_code);
  assign closes     = (is_text && !tok_byte) || is_end;

  // a fresh token starts at position zero
  assign eff_pos    = in_token ? tok_pos : '0;
  assign adv_fits   = (eff_pos < POS_W'(MAX_NAME_BYTES));
  // an open token that did not overrun the storage can still count
  assign close_live = in_token && (tok_pos <= POS_W'(MAX_NAME_BYTES));

  assign rd_en = accept && ((is_text && tok_byte && adv_fits) || (closes && close_live));

  // close reads the terminator row; a full-length token needs no terminator
  always_comb begin
    if (is_text && tok_byte) begin
      rd_addr = ROW_W'(eff_pos);
    end else if (tok_pos == POS_W'(MAX_NAME_BYTES)) begin
      rd_addr = '0;
    end else begin
      rd_addr = ROW_W'(tok_pos);
    end
  end

  // loads outside the table are dropped
  assign wr_load = accept && is_load &&
                   (int'(item.feature_slot) < NUM_FEATURES) &&
                   (int'(item.name_position) < MAX_NAME_BYTES);
  assign wr_lane = FEAT_W'(item.feature_slot);
  assign wr_row  = ROW_W'(item.name_position);

  // name memory: one write port, one registered read port; only one item is
  // in flight, so a write and a read of the same row never overlap
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      name_mem[clr_row] <= '0;
    end else if (wr_load) begin
      name_mem[wr_row][wr_lane*CHAR_W +: CHAR_W] <= item.char_code;
    end
    if (rd_en) begin
      rd_row <= name_mem[rd_addr];
    end
  end

  // result channel straight from the count registers
  assign rpt_last           = (rpt_idx == REP_W'(REPORTED - 1));
  assign result.valid       = (state == ST_REPORT);
  assign result.result_slot = SLOT_W'(rpt_idx);
  assign result.occurrences = hit_counts[rpt_idx];
  assign result.last_of_run = rpt_last;
  assign out_xfer           = result.valid && result.ready;

  always_comb begin
    counts_nonzero = 1'b0;
    for (int f = 0; f < NUM_FEATURES; f++) begin
      counts_nonzero = counts_nonzero | (hit_counts[f] != '0);
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_row        <= '0;
      tok_pos        <= '0;
      in_token       <= 1'b0;
      still_matching <= '0;
      end_pending    <= 1'b0;
      rpt_idx        <= '0;
      for (int f = 0; f < NUM_FEATURES; f++) begin
        hit_counts[f] <= '0;
      end
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == ROW_W'(MAX_NAME_BYTES - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            ch_q        <= item.char_code;
            end_pending <= is_end;
            if (is_text && tok_byte) begin
              in_token <= 1'b1;
              if (!in_token) begin
                still_matching <= '1;
              end
              if (adv_fits) begin
                tok_pos <= eff_pos;
                state   <= ST_STEP;
              end else begin
                // overlong token, matches nothing
                tok_pos <= POS_W'(MAX_NAME_BYTES + 1);
              end
            end else if (closes) begin
              if (close_live) begin
                state <= ST_CLOSE;
              end else begin
                in_token       <= 1'b0;
                tok_pos        <= '0;
                still_matching <= '0;
                if (is_end) begin
                  state <= ST_REPORT;
                end
              end
            end
          end
        end

        ST_STEP: begin
          // compare this byte against every name at the current position
          for (int f = 0; f < NUM_FEATURES; f++) begin
            if ((rd_row[f*CHAR_W +: CHAR_W] == '0) ||
                !byte_matches(rd_row[f*CHAR_W +: CHAR_W], ch_q)) begin
              still_matching[f] <= 1'b0;
            end
          end
          tok_pos <= tok_pos + 1'b1;
          state   <= ST_IDLE;
        end

        ST_CLOSE: begin
          // count names that matched so far and end exactly here
          for (int f = 0; f < NUM_FEATURES; f++) begin
            if (still_matching[f] &&
                ((tok_pos == POS_W'(MAX_NAME_BYTES)) ||
                 (rd_row[f*CHAR_W +: CHAR_W] == '0)) &&
                (hit_counts[f] != CNT_MAX)) begin
              hit_counts[f] <= hit_counts[f] + 1'b1;
            end
          end
          in_token       <= 1'b0;
          tok_pos        <= '0;
          still_matching <= '0;
          state          <= end_pending ? ST_REPORT : ST_IDLE;
        end

        ST_REPORT: begin
          if (out_xfer) begin
            if (rpt_last) begin
              rpt_idx <= '0;
              state   <= ST_IDLE;
              for (int f = 0; f < NUM_FEATURES; f++) begin
                hit_counts[f] <= '0;
              end
            end else begin
              rpt_idx <= rpt_idx + 1'b1;
            end
          end
        end

        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // counts are gone once the final count of a run has been taken
  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && result.last_of_run) |=> !counts_nonzero)
    else $error("counts not cleared after end-of-text run");

  // name memory is never written and read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && (wr_load || (state == ST_CLEAR))))
    else $error("name memory read and write overlap");

  // token position stays within one past the storage
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    tok_pos <= POS_W'(MAX_NAME_BYTES + 1))
    else $error("token position overrun");

  // with no open token the position rests at zero between items
  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && !in_token) |-> (tok_pos == '0))
    else $error("stale token position outside a token");

  // a compare step always follows a read issued for a token byte
  a_step_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> $past(rd_en))
    else $error("compare step without memory read");

endmodule

`default_nettype wire
